// ----- rtl/core/fha_pkg.sv -----
`default_nettype none

package fha_pkg;

   // Field and header widths, size bound and default heap depth
   localparam int unsigned HDR_W          = 13;
   localparam int unsigned WRD_W          = 12;
   localparam int unsigned SIZE_W         = 16;
   localparam int unsigned ADDR_W         = 12;
   localparam int unsigned NEED_W         = 15;
   localparam int unsigned NEED_MAX       = 16384;
   localparam int unsigned MEM_ADDR_W     = 16;
   localparam int unsigned HEAP_WORDS_DEF = 4096;

   // Request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [SIZE_W-1:0] size_bytes;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] payload_address;
      logic              success;
   } rsp_type;

   // One access to the header memory
   typedef struct packed {
      logic                  we;
      logic [MEM_ADDR_W-1:0] addr;
      logic [HDR_W-1:0]      wdata;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_WR2,
      ST_F_RDH,
      ST_F_CHKH,
      ST_F_RDN,
      ST_F_CHKN,
      ST_F_RDK,
      ST_F_CHKK
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/fha_mem.sv -----
`default_nettype none

module fha_mem
   import fha_pkg::*;
#(
   parameter int unsigned HEAP_WORDS = HEAP_WORDS_DEF
) (
   input  wire logic              clock,
   input  wire mem_req_type       mem_req,
   output logic      [HDR_W-1:0]  mem_rdata
);

   localparam int unsigned IDX_W = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;

   logic [HDR_W-1:0] mem [HEAP_WORDS];
   logic [HDR_W-1:0] rdata_ff;
   logic [IDX_W-1:0] idx;

   assign idx = mem_req.addr[IDX_W-1:0];

   // Write one header, read one header with a registered output
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[idx] <= mem_req.wdata;
      end
      rdata_ff <= mem[idx];
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/fha_ctrl.sv -----
`default_nettype none

module fha_ctrl
   import fha_pkg::*;
#(
   parameter int unsigned HEAP_WORDS = HEAP_WORDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   output mem_req_type            mem_req,
   input  wire logic [HDR_W-1:0]  mem_rdata
);

   localparam int unsigned IDX_W = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
   localparam int unsigned SUM_W = $clog2(HEAP_WORDS + NEED_MAX + 2) + 1;
   localparam logic [SUM_W-1:0] HEAP_END  = SUM_W'(HEAP_WORDS);
   localparam logic [SUM_W-1:0] SUM_ONE   = SUM_W'(1);
   localparam logic [WRD_W-1:0] WRD_ONE   = WRD_W'(1);
   localparam logic [WRD_W-1:0] INIT_WRDS = WRD_W'(HEAP_WORDS - 1);

   state_type state_ff, state_in;

   logic [NEED_W-1:0] need_ff;
   logic [IDX_W-1:0]  pos_ff;
   logic [IDX_W-1:0]  rest_ff;
   logic [WRD_W-1:0]  have_ff;
   logic [IDX_W-1:0]  hdr_ff;
   logic [IDX_W-1:0]  nxt_ff;
   logic [WRD_W-1:0]  hw_ff;
   logic [IDX_W-1:0]  k_ff;
   logic              rsp_strobe_ff;
   rsp_type           rsp_data_ff;

   logic              rd_used;
   logic [WRD_W-1:0]  rd_words;
   logic              accept;
   logic              addr_ok;
   logic              fit;
   logic [SUM_W-1:0]  pos_sum;
   logic [SUM_W-1:0]  rest_sum;
   logic [WRD_W-1:0]  rest_words;
   logic [SUM_W-1:0]  pay_sum;
   logic [SUM_W-1:0]  nxt_sum;
   logic [WRD_W-1:0]  merge_words;
   logic [SUM_W-1:0]  k_end;
   logic              k_match;
   logic [WRD_W-1:0]  k_words;
   logic [WRD_W-1:0]  k_step;
   logic [SUM_W-1:0]  k_sum;
   logic              fin;
   logic              fin_ok;
   logic [ADDR_W-1:0] fin_addr;

   // Decode the header just read and form the walk sums
   assign rd_used     = mem_rdata[0];
   assign rd_words    = mem_rdata[HDR_W-1:1];
   assign accept      = start && !busy;
   assign addr_ok     = (req_data.block_address != '0) &&
                        (SUM_W'(req_data.block_address) < HEAP_END);
   assign fit         = !rd_used && (NEED_W'(rd_words) > need_ff);
   assign pos_sum     = SUM_W'(pos_ff) + SUM_W'(rd_words) + SUM_ONE;
   assign rest_sum    = SUM_W'(pos_ff) + SUM_W'(need_ff) + SUM_ONE;
   assign rest_words  = have_ff - need_ff[WRD_W-1:0] - WRD_ONE;
   assign pay_sum     = SUM_W'(pos_ff) + SUM_ONE;
   assign nxt_sum     = SUM_W'(hdr_ff) + SUM_W'(rd_words) + SUM_ONE;
   assign merge_words = hw_ff + rd_words + WRD_ONE;
   assign k_end       = SUM_W'(k_ff) + SUM_W'(rd_words) + SUM_ONE;
   assign k_match     = !rd_used && (k_end == SUM_W'(hdr_ff));
   assign k_words     = rd_words + hw_ff + WRD_ONE;
   assign k_step      = k_match ? k_words : rd_words;
   assign k_sum       = SUM_W'(k_ff) + SUM_W'(k_step) + SUM_ONE;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (req_data.kind == KIND_ALLOC) begin
                  state_in = ST_A_RD;
               end else if (addr_ok) begin
                  state_in = ST_F_RDH;
               end
            end
         end
         ST_A_RD: begin
            state_in = ST_A_CHK;
         end
         ST_A_CHK: begin
            if (fit) begin
               state_in = (rest_sum < HEAP_END) ? ST_A_WR2 : ST_IDLE;
            end else begin
               state_in = (pos_sum < HEAP_END) ? ST_A_RD : ST_IDLE;
            end
         end
         ST_A_WR2: begin
            state_in = ST_IDLE;
         end
         ST_F_RDH: begin
            state_in = ST_F_CHKH;
         end
         ST_F_CHKH: begin
            if (nxt_sum < HEAP_END) begin
               state_in = ST_F_RDN;
            end else begin
               state_in = (hdr_ff != '0) ? ST_F_RDK : ST_IDLE;
            end
         end
         ST_F_RDN: begin
            state_in = ST_F_CHKN;
         end
         ST_F_CHKN: begin
            state_in = (hdr_ff != '0) ? ST_F_RDK : ST_IDLE;
         end
         ST_F_RDK: begin
            state_in = ST_F_CHKK;
         end
         ST_F_CHKK: begin
            state_in = (k_sum < SUM_W'(hdr_ff)) ? ST_F_RDK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory access and completion per state
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      mem_req.we    = 1'b0;
      mem_req.addr  = MEM_ADDR_W'(pos_ff);
      mem_req.wdata = '0;
      fin           = 1'b0;
      fin_ok        = 1'b0;
      fin_addr      = '0;
      unique case (state_ff)
         ST_INIT: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = '0;
            mem_req.wdata = {INIT_WRDS, 1'b0};
         end
         ST_IDLE: begin
            if (start && (req_data.kind == KIND_FREE) && !addr_ok) begin
               fin = 1'b1;
            end
         end
         ST_A_RD: begin
            mem_req.addr = MEM_ADDR_W'(pos_ff);
         end
         ST_A_CHK: begin
            if (fit) begin
               mem_req.we    = 1'b1;
               mem_req.addr  = MEM_ADDR_W'(pos_ff);
               mem_req.wdata = {need_ff[WRD_W-1:0], 1'b1};
               if (!(rest_sum < HEAP_END)) begin
                  fin      = 1'b1;
                  fin_ok   = 1'b1;
                  fin_addr = pay_sum[ADDR_W-1:0];
               end
            end else if (!(pos_sum < HEAP_END)) begin
               fin = 1'b1;
            end
         end
         ST_A_WR2: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = MEM_ADDR_W'(rest_ff);
            mem_req.wdata = {rest_words, 1'b0};
            fin           = 1'b1;
            fin_ok        = 1'b1;
            fin_addr      = pay_sum[ADDR_W-1:0];
         end
         ST_F_RDH: begin
            mem_req.addr = MEM_ADDR_W'(hdr_ff);
         end
         ST_F_CHKH: begin
            mem_req.addr = MEM_ADDR_W'(hdr_ff);
            if (!(nxt_sum < HEAP_END)) begin
               mem_req.we    = 1'b1;
               mem_req.wdata = {rd_words, 1'b0};
               if (hdr_ff == '0) begin
                  fin    = 1'b1;
                  fin_ok = 1'b1;
               end
            end
         end
         ST_F_RDN: begin
            mem_req.addr = MEM_ADDR_W'(nxt_ff);
         end
         ST_F_CHKN: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = MEM_ADDR_W'(hdr_ff);
            mem_req.wdata = {(rd_used ? hw_ff : merge_words), 1'b0};
            if (hdr_ff == '0) begin
               fin    = 1'b1;
               fin_ok = 1'b1;
            end
         end
         ST_F_RDK: begin
            mem_req.addr = MEM_ADDR_W'(k_ff);
         end
         ST_F_CHKK: begin
            mem_req.addr = MEM_ADDR_W'(k_ff);
            if (k_match) begin
               mem_req.we    = 1'b1;
               mem_req.wdata = {k_words, 1'b0};
            end
            if (!(k_sum < SUM_W'(hdr_ff))) begin
               fin    = 1'b1;
               fin_ok = 1'b1;
            end
         end
         default: begin
            fin = 1'b0;
         end
      endcase
   end

   // Advance the state and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= fin;
      end
   end

   // Hold the walk position, sizes and result
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               need_ff <= NEED_W'((SIZE_W + 1)'(req_data.size_bytes) + (SIZE_W + 1)'(3) >> 2);
               pos_ff  <= '0;
               hdr_ff  <= IDX_W'(SUM_W'(req_data.block_address) - SUM_ONE);
            end
         end
         ST_A_CHK: begin
            have_ff <= rd_words;
            rest_ff <= rest_sum[IDX_W-1:0];
            if (!fit) begin
               pos_ff <= pos_sum[IDX_W-1:0];
            end
         end
         ST_F_CHKH: begin
            hw_ff  <= rd_words;
            nxt_ff <= nxt_sum[IDX_W-1:0];
            k_ff   <= '0;
         end
         ST_F_CHKN: begin
            if (!rd_used) begin
               hw_ff <= merge_words;
            end
         end
         ST_F_CHKK: begin
            k_ff <= k_sum[IDX_W-1:0];
         end
         default: begin
            k_ff <= k_ff;
         end
      endcase
      if (fin) begin
         rsp_data_ff.payload_address <= fin_addr;
         rsp_data_ff.success         <= fin_ok;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_heap_allocator.sv -----
// Sequence: allocate reads and checks each header from word 0, writes the remainder
//   header when one fits and presents the registered result; free checks its own
//   header and any next one, walks the blocks before it from word 0 and presents the
//   result; a free of address 0 or outside the heap is answered in the next cycle.
// Throughput: one request at a time; one-cycle result strobe, the receiver cannot stall.
// Reset: synchronous; the INIT state after reset writes the whole-heap free header to word 0.
`default_nettype none

module first_fit_heap_allocator
   import fha_pkg::*;
#(
   parameter int unsigned HEAP_WORDS = HEAP_WORDS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   mem_req_type      mem_req;
   logic [HDR_W-1:0] mem_rdata;

   // Walk control and datapath
   fha_ctrl #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

   // Header store
   fha_mem #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

endmodule

`default_nettype wire

// ----- rtl/core/fha_checker.sv -----
`default_nettype none

module fha_checker
   import fha_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   // Drop the address on a failed result
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.success |-> rsp_data.payload_address == '0)
      else $error("failed result carries an address");

   // Present a result whenever the walk ends
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) && !$past(reset, 2) |-> rsp_strobe)
      else $error("walk ended without a result");

   // Go busy or answer at once after a request
   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("request neither started nor answered");

   // Hold results to idle cycles
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

endmodule

bind first_fit_heap_allocator fha_checker u_fha_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
